// ===== rtl/roman_numeral_encoder_defines.svh =====
// Assertion macros shared by the Roman numeral encoder RTL.
`ifndef ROMAN_NUMERAL_ENCODER_DEFINES_SVH
`define ROMAN_NUMERAL_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define RNE_ASSERT_IMPL(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) cond) \
    else $error("roman numeral encoder check failed");
`define RNE_ASSERT_NEXT(lbl, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (rst) cause |=> effect) \
    else $error("roman numeral encoder sequence check failed");
`else
`define RNE_ASSERT_IMPL(lbl, cond)
`define RNE_ASSERT_NEXT(lbl, cause, effect)
`endif
`endif

// ===== rtl/rne_pkg.sv =====
// Types and constants shared by the Roman numeral encoder modules.
package rne_pkg;

  typedef logic [1:0] status_t;
  typedef logic [3:0] digit_t;

  localparam status_t ST_VALID = 2'd0;
  localparam status_t ST_ZERO  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  localparam logic [11:0] VALUE_MAX = 12'd3999;

  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_V = 8'h56;
  localparam logic [7:0] CH_I = 8'h49;

  // Status and decimal digits of one value, digit index 0 holds the units.
  typedef struct packed {
    status_t         status;
    logic [3:0][3:0] digit;
  } item_t;

endpackage

// ===== rtl/rne_front.sv =====
// Three-stage pipeline that checks the value and splits it into decimal digits.
module rne_front import rne_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] value,
  output logic        item_valid,
  input  logic        item_take,
  output item_t       item
);
`include "roman_numeral_encoder_defines.svh"

  logic        v1;
  logic        v2;
  logic        v3;
  logic        adv1;
  logic        adv2;
  logic        adv3;
  status_t     st1;
  status_t     st2;
  status_t     st3;
  digit_t      d3_1;
  digit_t      d3_2;
  digit_t      d3_3;
  digit_t      d2_2;
  digit_t      d2_3;
  digit_t      d1_3;
  digit_t      d0_3;
  logic [9:0]  rem1;
  logic [6:0]  rem2;
  status_t     st_next;
  digit_t      d3_next;
  logic [11:0] thou_sub;
  digit_t      d2_next;
  logic [9:0]  hund_sub;
  digit_t      d1_next;
  logic [6:0]  ten_sub;

  assign adv3     = !v3 || item_take;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;

  always_comb begin
    if (value == 12'd0) begin
      st_next = ST_ZERO;
    end else if (value > VALUE_MAX) begin
      st_next = ST_RANGE;
    end else begin
      st_next = ST_VALID;
    end
    if (value >= 12'd3000) begin
      d3_next  = 4'd3;
      thou_sub = 12'd3000;
    end else if (value >= 12'd2000) begin
      d3_next  = 4'd2;
      thou_sub = 12'd2000;
    end else if (value >= 12'd1000) begin
      d3_next  = 4'd1;
      thou_sub = 12'd1000;
    end else begin
      d3_next  = 4'd0;
      thou_sub = 12'd0;
    end
  end

  always_comb begin
    d2_next = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem1 >= 10'(k * 100)) begin
        d2_next = 4'(k);
      end
    end
    hund_sub = {6'd0, d2_next} * 10'd100;
  end

  always_comb begin
    d1_next = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem2 >= 7'(k * 10)) begin
        d1_next = 4'(k);
      end
    end
    ten_sub = {3'd0, d1_next} * 7'd10;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      st1  <= st_next;
      d3_1 <= d3_next;
      rem1 <= 10'(value - thou_sub);
    end
    if (adv2) begin
      st2  <= st1;
      d3_2 <= d3_1;
      d2_2 <= d2_next;
      rem2 <= 7'(rem1 - hund_sub);
    end
    if (adv3) begin
      st3  <= st2;
      d3_3 <= d3_2;
      d2_3 <= d2_2;
      d1_3 <= d1_next;
      d0_3 <= 4'(rem2 - ten_sub);
    end
  end

  assign item_valid  = v3;
  assign item.status = st3;
  assign item.digit  = {d3_3, d2_3, d1_3, d0_3};

  `RNE_ASSERT_IMPL(a_digits_decimal, v3 && st3 == ST_VALID |-> d0_3 <= 4'd9 && d1_3 <= 4'd9 && d2_3 <= 4'd9 && d3_3 <= 4'd3)

endmodule

// ===== rtl/rne_serializer.sv =====
// Serializer that turns decimal digits into numeral characters, one per beat.
module rne_serializer import rne_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_take,
  input  item_t       item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  symbol,
  output logic        last,
  output status_t     status
);
`include "roman_numeral_encoder_defines.svh"

  localparam logic [1:0] SEL_ONE  = 2'd0;
  localparam logic [1:0] SEL_FIVE = 2'd1;
  localparam logic [1:0] SEL_TEN  = 2'd2;

  function automatic logic [2:0] digit_len(input digit_t d);
    logic [2:0] len;
    case (d)
      4'd1, 4'd5:             len = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: len = 3'd2;
      4'd3, 4'd7:             len = 3'd3;
      4'd8:                   len = 3'd4;
      default:                len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] digit_sel(input digit_t d, input logic [1:0] p);
    logic [1:0] sel;
    case (d)
      4'd4:             sel = (p == 2'd0) ? SEL_ONE : SEL_FIVE;
      4'd5:             sel = SEL_FIVE;
      4'd6, 4'd7, 4'd8: sel = (p == 2'd0) ? SEL_FIVE : SEL_ONE;
      4'd9:             sel = (p == 2'd0) ? SEL_ONE : SEL_TEN;
      default:          sel = SEL_ONE;
    endcase
    return sel;
  endfunction

  function automatic logic [1:0] top_index(input logic [3:0] m);
    logic [1:0] ix;
    ix = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (m[i]) begin
        ix = 2'(i);
      end
    end
    return ix;
  endfunction

  function automatic logic [7:0] place_char(input logic [1:0] place, input logic [1:0] sel);
    logic [7:0] ch;
    case (place)
      2'd0:    ch = (sel == SEL_ONE) ? CH_I : (sel == SEL_FIVE) ? CH_V : CH_X;
      2'd1:    ch = (sel == SEL_ONE) ? CH_X : (sel == SEL_FIVE) ? CH_L : CH_C;
      2'd2:    ch = (sel == SEL_ONE) ? CH_C : (sel == SEL_FIVE) ? CH_D : CH_M;
      default: ch = CH_M;
    endcase
    return ch;
  endfunction

  logic            busy;
  status_t         cur_status;
  logic [3:0][3:0] digit;
  logic [1:0]      idx;
  logic [1:0]      pos;
  logic            emit_ok;
  logic            emit;
  logic [3:0]      nz;
  logic [3:0]      lower;
  logic [3:0]      item_nz;
  logic [2:0]      cur_len;
  logic            digit_end;
  logic            item_end;
  logic [7:0]      cur_char;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nz[i]      = digit[i] != 4'd0;
      item_nz[i] = item.digit[i] != 4'd0;
      lower[i]   = nz[i] && (2'(i) < idx);
    end
  end

  assign cur_len   = digit_len(digit[idx]);
  assign digit_end = {1'b0, pos} == cur_len - 3'd1;
  assign item_end  = (cur_status != ST_VALID) || (digit_end && lower == 4'd0);
  assign cur_char  = (cur_status == ST_VALID) ?
                     place_char(idx, digit_sel(digit[idx], pos)) : 8'd0;
  assign emit_ok   = !out_valid || !out_stall;
  assign emit      = busy && emit_ok;
  assign item_take = item_valid && (!busy || (emit && item_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item_take) begin
        busy <= 1'b1;
      end else if (emit && item_end) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      symbol <= cur_char;
      last   <= item_end;
      status <= cur_status;
    end
    if (item_take) begin
      cur_status <= item.status;
      digit      <= item.digit;
      idx        <= top_index(item_nz);
      pos        <= 2'd0;
    end else if (emit) begin
      if (digit_end) begin
        idx <= top_index(lower);
        pos <= 2'd0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  `RNE_ASSERT_IMPL(a_flag_is_last, out_valid && status != ST_VALID |-> last)
  `RNE_ASSERT_IMPL(a_digit_live, busy && cur_status == ST_VALID |-> nz[idx] && {1'b0, pos} < cur_len)
  `RNE_ASSERT_NEXT(a_stay_busy, emit && !item_end, busy && out_valid)

endmodule

// ===== rtl/roman_numeral_encoder.sv =====
// Top level of the Roman numeral encoder: digit split pipeline and serializer.
// A value passes through the front pipeline stages, the serializer's digit registers
// and the output register. Throughput: one character per cycle while out_stall is low;
// a value yields as many characters as its numeral has (1 to 15, one for zero or
// out of range). Consecutive values follow back to back when the next one is waiting.
// Reset clears all valid bits; payload registers keep their contents.
module roman_numeral_encoder import rne_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  symbol,
  output logic        last,
  output logic [1:0]  status
);

  logic  item_valid;
  logic  item_take;
  item_t item;

  rne_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  rne_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .symbol     (symbol),
    .last       (last),
    .status     (status)
  );

endmodule
